// ===== rtl/bal_pkg.sv =====
`default_nettype none

package bal_pkg;

  localparam int ACT_W   = 3;
  localparam int POS_W   = 5;
  localparam int CAP_W   = 5;
  localparam int VALUE_W = 32;
  localparam int CNT_O_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_SELECT  = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_REPLACE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MOVE = 2'd1,
    S_DONE = 2'd2
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_array_list_unit.sv =====
// Bounded ordered list held in one synchronous memory of DEPTH words.
// Input channel (in_valid / in_stall): one item carries an action, a position
// and a value. Result channel (out_valid / out_stall): one result per item
// with ok, read_value, found_position, count, is_empty and is_full.
// cfg_wr_en with cfg_wr_data sets the capacity; write it only while idle.
// One item is worked on at a time and in_stall stays high until its result
// has been loaded into the output register. The memory has one read and one
// write port, so shifting and searching move through one entry per cycle.
// Select, replace, failed operations and unused codes go from idle straight
// to the done state. Insert and remove pass through the move state, which
// reads and rewrites one entry at a time; insert at position p over n entries
// shifts n - p of them and remove shifts n - p - 1. A search scans upward from
// position 0 and stops at the first match, or after all n entries on a miss.
// A new item can be accepted in the cycle after the result is loaded, even
// while that result is still stalled in the output register; a stalled result
// holds and blocks only the completion of the following item.
// Reset empties the list and sets the capacity to 16. Entries at or past the
// count are never read, so the memory needs no clearing pass after reset.
`default_nettype none

module bounded_array_list_unit #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [bal_pkg::CAP_W-1:0]      cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [bal_pkg::ACT_W-1:0]      in_action,
  input  wire logic        [bal_pkg::POS_W-1:0]      in_position,
  input  wire logic signed [bal_pkg::VALUE_W-1:0]    in_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_ok,
  output logic signed      [bal_pkg::VALUE_W-1:0]    out_read_value,
  output logic             [bal_pkg::CNT_O_W-1:0]    out_found_position,
  output logic             [bal_pkg::CNT_O_W-1:0]    out_count,
  output logic                                       out_is_empty,
  output logic                                       out_is_full
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW0   = (CNT_W > bal_pkg::POS_W) ? CNT_W : bal_pkg::POS_W;
  localparam int CW    = (CW0 > bal_pkg::CAP_W) ? CW0 : bal_pkg::CAP_W;
  localparam int DW    = (WIDTH > bal_pkg::VALUE_W) ? WIDTH : bal_pkg::VALUE_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [WIDTH-1:0] mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;
  logic [WIDTH-1:0] rdata_r;

  bal_pkg::state_t  state_r, state_nxt;
  bal_pkg::action_t op_r, op_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] fpos_r, fpos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [bal_pkg::CAP_W-1:0] cap_r;
  logic [AW-1:0]    src_r, src_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_ok_r, out_ok_nxt;
  logic [bal_pkg::VALUE_W-1:0]      out_rd_r, out_rd_nxt;
  logic [bal_pkg::CNT_O_W-1:0]      out_fpos_r, out_fpos_nxt;
  logic [bal_pkg::CNT_O_W-1:0]      out_count_r, out_count_nxt;
  logic                             out_empty_r, out_empty_nxt;
  logic                             out_full_r, out_full_nxt;

  logic [DW-1:0]    val_ext;
  logic [WIDTH-1:0] in_val;
  logic [DW-1:0]    rd_ext;
  logic [CW-1:0]    in_posx;
  logic [CW-1:0]    nx;
  logic [CW-1:0]    capx;
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    fpos_x;
  logic [CW-1:0]    count_x;
  logic             out_free;
  logic             hit;
  logic             in_acc;

  assign val_ext = DW'($unsigned(in_value));
  assign in_val  = val_ext[WIDTH-1:0];
  assign rd_ext  = DW'(rdata_r);
  assign in_posx = CW'(in_position);
  assign nx      = CW'(count_r);
  assign capx    = CW'(cap_r);
  assign eff_cap = (capx > CW'(DEPTH)) ? CW'(DEPTH) : capx;
  assign fpos_x  = CW'(fpos_r);
  assign count_x = CW'(count_r);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (state_r != bal_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    fpos_nxt      = fpos_r;
    count_nxt     = count_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    hit           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    out_fpos_nxt  = out_fpos_r;
    out_count_nxt = out_count_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      bal_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = bal_pkg::action_t'(in_action);
          pos_nxt   = in_posx;
          val_nxt   = in_val;
          ok_nxt    = 1'b0;
          fpos_nxt  = '0;
          pend_nxt  = 1'b0;
          left_nxt  = '0;
          state_nxt = bal_pkg::S_DONE;
          unique case (in_action)
            bal_pkg::ACT_INSERT: begin
              if (in_posx <= nx && nx < eff_cap) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r + 1'b1;
                left_nxt  = CNT_W'(nx - in_posx);
                src_nxt   = AW'(nx - CW'(1));
                state_nxt = bal_pkg::S_MOVE;
              end
            end
            bal_pkg::ACT_REMOVE: begin
              if (in_posx < nx) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - 1'b1;
                left_nxt  = CNT_W'(nx - in_posx - CW'(1));
                src_nxt   = AW'(in_posx + CW'(1));
                state_nxt = bal_pkg::S_MOVE;
              end
            end
            bal_pkg::ACT_SELECT: begin
              ok_nxt = (in_posx < nx);
              if (nx != '0) begin
                mem_re = 1'b1;
                mem_ra = (in_posx < nx) ? AW'(in_posx) : AW'(nx - CW'(1));
              end
            end
            bal_pkg::ACT_SEARCH: begin
              fpos_nxt  = count_r;
              left_nxt  = count_r;
              src_nxt   = '0;
              state_nxt = bal_pkg::S_MOVE;
            end
            bal_pkg::ACT_REPLACE: begin
              if (in_posx < nx) begin
                ok_nxt = 1'b1;
                mem_we = 1'b1;
                mem_wa = AW'(in_posx);
                mem_wd = in_val;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bal_pkg::S_MOVE: begin
        if (pend_r) begin
          priority if (op_r == bal_pkg::ACT_INSERT) begin
            mem_we = 1'b1;
            mem_wa = pidx_r + 1'b1;
            mem_wd = rdata_r;
          end else if (op_r == bal_pkg::ACT_REMOVE) begin
            mem_we = 1'b1;
            mem_wa = pidx_r - 1'b1;
            mem_wd = rdata_r;
          end else begin
            hit = (rdata_r == val_r);
          end
        end
        pend_nxt = 1'b0;
        priority if (hit) begin
          ok_nxt    = 1'b1;
          fpos_nxt  = CNT_W'(pidx_r);
          left_nxt  = '0;
          state_nxt = bal_pkg::S_DONE;
        end else if (left_r != '0) begin
          mem_re   = 1'b1;
          mem_ra   = src_r;
          pend_nxt = 1'b1;
          pidx_nxt = src_r;
          left_nxt = left_r - 1'b1;
          src_nxt  = (op_r == bal_pkg::ACT_INSERT) ? src_r - 1'b1 : src_r + 1'b1;
        end else if (!pend_r) begin
          if (op_r == bal_pkg::ACT_INSERT) begin
            mem_we = 1'b1;
            mem_wa = AW'(pos_r);
            mem_wd = val_r;
          end
          state_nxt = bal_pkg::S_DONE;
        end else begin
          state_nxt = bal_pkg::S_MOVE;
        end
      end

      bal_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_rd_nxt    = (op_r == bal_pkg::ACT_SELECT && count_r != '0) ?
                          rd_ext[bal_pkg::VALUE_W-1:0] : '0;
          out_fpos_nxt  = fpos_x[bal_pkg::CNT_O_W-1:0];
          out_count_nxt = count_x[bal_pkg::CNT_O_W-1:0];
          out_empty_nxt = (count_r == '0);
          out_full_nxt  = (count_x >= eff_cap);
          state_nxt     = bal_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bal_pkg::S_IDLE;
      count_r     <= '0;
      cap_r       <= bal_pkg::CAP_RESET;
      pend_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    fpos_r      <= fpos_nxt;
    src_r       <= src_nxt;
    pidx_r      <= pidx_nxt;
    out_ok_r    <= out_ok_nxt;
    out_rd_r    <= out_rd_nxt;
    out_fpos_r  <= out_fpos_nxt;
    out_count_r <= out_count_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;
  assign out_is_empty       = out_empty_r;
  assign out_is_full        = out_full_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(DEPTH))
    else $error("entry count exceeds the memory depth");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("entry count changed without an accepted item");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                count_r + 1'b1 == $past(count_r)))
    else $error("entry count moved by more than one");

  a_pend_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == bal_pkg::S_MOVE)
    else $error("read in flight outside the shift or scan phase");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_wa != mem_ra)
    else $error("memory read and write hit the same entry");
`endif

endmodule

`default_nettype wire
